### rtl/tcgr_pkg.sv
// Package for the text cell glyph renderer: item types, request codes, color helper.
package tcgr_pkg;

  localparam int unsigned FontWordsDefault = 256;
  localparam logic [15:0] BlinkHalfReset   = 16'd50000;

  typedef enum logic [1:0] {
    REQ_TICK = 2'd0,
    REQ_FONT = 2'd1,
    REQ_PAL  = 2'd2,
    REQ_CELL = 2'd3
  } req_type_e;

  typedef struct packed {
    req_type_e   req_type;
    logic [7:0]  store_addr;
    logic [15:0] store_data;
    logic [15:0] cell_word;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  pixel_row;
    logic [23:0] pixel_col0;
    logic [23:0] pixel_col1;
    logic [23:0] pixel_col2;
    logic [23:0] pixel_col3;
    logic        last_row;
  } out_item_t;

  // cell load request handed to the row generator
  typedef struct packed {
    logic load;
    logic blink;
  } cell_ctl_t;

  // row generator occupancy
  typedef struct packed {
    logic busy;
    logic release_now;
  } row_stat_t;

  // 4-bit channels to 8 bits (x 0x11 is nibble duplication)
  function automatic logic [23:0] expand_color(input logic [11:0] c);
    expand_color = {c[11:8], c[11:8], c[7:4], c[7:4], c[3:0], c[3:0]};
  endfunction

endpackage

### rtl/tcgr_font_mem.sv
// Font store: even and odd glyph word banks, one write port, registered reads.
module tcgr_font_mem import tcgr_pkg::*; #(
  parameter int unsigned FONT_WORDS = FontWordsDefault
) (
  input  logic        clk_i,
  input  logic        we_i,
  input  logic [$clog2(FONT_WORDS)-1:0] waddr_i,
  input  logic [15:0] wdata_i,
  input  logic        re_i,
  input  logic [$clog2(FONT_WORDS)-2:0] rindex_i,
  output logic [15:0] word0_o,
  output logic [15:0] word1_o
);

  localparam int unsigned BankDepth = FONT_WORDS / 2;
  localparam int unsigned FontAw    = $clog2(FONT_WORDS);

  logic [15:0] even_mem [BankDepth];
  logic [15:0] odd_mem  [BankDepth];
  logic [15:0] word0_q, word1_q;

  always_ff @(posedge clk_i) begin
    if (we_i && !waddr_i[0]) begin
      even_mem[waddr_i[FontAw-1:1]] <= wdata_i;
    end
    if (we_i && waddr_i[0]) begin
      odd_mem[waddr_i[FontAw-1:1]] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      word0_q <= even_mem[rindex_i];
      word1_q <= odd_mem[rindex_i];
    end
  end

  assign word0_o = word0_q;
  assign word1_o = word1_q;

endmodule

### rtl/tcgr_palette_mem.sv
// Palette store: 16 x 12-bit colors, one write port, two registered read ports.
module tcgr_palette_mem import tcgr_pkg::*; (
  input  logic        clk_i,
  input  logic        we_i,
  input  logic [3:0]  waddr_i,
  input  logic [11:0] wdata_i,
  input  logic        re_i,
  input  logic [3:0]  fg_idx_i,
  input  logic [3:0]  bg_idx_i,
  output logic [11:0] fg_o,
  output logic [11:0] bg_o
);

  logic [11:0] pal_mem [16];
  logic [11:0] fg_q, bg_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      pal_mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      fg_q <= pal_mem[fg_idx_i];
      bg_q <= pal_mem[bg_idx_i];
    end
  end

  assign fg_o = fg_q;
  assign bg_o = bg_q;

endmodule

### rtl/tcgr_blink.sv
// Blink counter with its half period register and phase compare.
module tcgr_blink import tcgr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        tick_i,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_data_i,
  output logic        blink_on_o
);

  logic [15:0] half_q, half_d;
  logic [16:0] count_q, count_d;
  logic [16:0] inc;
  logic [16:0] lim;

  always_comb begin
    lim    = {half_q, 1'b0};
    inc    = count_q + 17'd1;
    half_d = cfg_we_i ? cfg_data_i : half_q;
    count_d = count_q;
    if (tick_i) begin
      count_d = (inc > lim) ? (inc - lim) : inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q  <= BlinkHalfReset;
      count_q <= '0;
    end else begin
      half_q  <= half_d;
      count_q <= count_d;
    end
  end

  assign blink_on_o = count_q > {1'b0, half_q};

  // a tick from within the wrap limit stays within it (limit nonzero)
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(tick_i) && $stable(half_q) && (half_q != '0) &&
    ($past(count_q) <= {half_q, 1'b0}) |-> count_q <= {half_q, 1'b0})
    else $error("blink count above wrap limit");

  // the counter only moves on a tick
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !tick_i |=> $stable(count_q))
    else $error("blink count moved without tick");

  // a tick moves the counter
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_i && (half_q != '0) |=> !$stable(count_q))
    else $error("blink count stuck on tick");

endmodule

### rtl/tcgr_row_gen.sv
// Row generator: turns one cell's glyph and colors into eight rows in an output register.
module tcgr_row_gen import tcgr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cell_ctl_t   ctl_i,
  input  logic [15:0] word0_i,
  input  logic [15:0] word1_i,
  input  logic [11:0] fg_i,
  input  logic [11:0] bg_i,
  output row_stat_t   stat_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_data_o
);

  logic      busy_q, busy_d;
  logic      blink_q, blink_d;
  logic [2:0] row_q, row_d;
  logic      ovalid_q, ovalid_d;
  out_item_t odata_q, odata_d;
  logic      out_free;
  logic      emit;
  logic      done;
  logic [23:0] fg_c, bg_c;

  assign out_free = !ovalid_q || !out_stall_i;
  assign emit     = busy_q && out_free;
  assign done     = emit && (row_q == 3'd7);

  always_comb begin
    bg_c = expand_color(bg_i);
    fg_c = blink_q ? bg_c : expand_color(fg_i);

    busy_d  = busy_q;
    blink_d = blink_q;
    row_d   = row_q;
    if (emit) begin
      row_d = row_q + 3'd1;
    end
    if (done) begin
      busy_d = 1'b0;
    end
    if (ctl_i.load) begin
      busy_d  = 1'b1;
      blink_d = ctl_i.blink;
      row_d   = '0;
    end

    ovalid_d = ovalid_q && out_stall_i;
    odata_d  = odata_q;
    if (emit) begin
      ovalid_d           = 1'b1;
      odata_d.pixel_row  = row_q;
      odata_d.pixel_col0 = word0_i[{1'b1, row_q}] ? fg_c : bg_c;
      odata_d.pixel_col1 = word0_i[{1'b0, row_q}] ? fg_c : bg_c;
      odata_d.pixel_col2 = word1_i[{1'b1, row_q}] ? fg_c : bg_c;
      odata_d.pixel_col3 = word1_i[{1'b0, row_q}] ? fg_c : bg_c;
      odata_d.last_row   = (row_q == 3'd7);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      row_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      busy_q   <= busy_d;
      row_q    <= row_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    blink_q <= blink_d;
    odata_q <= odata_d;
  end

  assign stat_o.busy        = busy_q;
  assign stat_o.release_now = done;
  assign out_valid_o        = ovalid_q;
  assign out_data_o         = odata_q;

  // a cell is only released after its eighth row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_q) |-> $past(row_q) == 3'd7)
    else $error("cell released before last row");

  // a new cell never lands on one still emitting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.load |-> !busy_q || done)
    else $error("cell load overran row generator");

  // last_row flag tracks the row number
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q |-> odata_q.last_row == (odata_q.pixel_row == 3'd7))
    else $error("last_row mismatch");

  // a load starts at row zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.load |=> busy_q && (row_q == 3'd0))
    else $error("load did not start at top row");

endmodule

### rtl/text_cell_glyph_renderer_top.sv
// Top level of the text cell glyph renderer (text-mode character generator with blink).
//
// Input channel (in_valid_i / in_stall_o / in_data_i): one transfer per request.
//   Tick, font write and palette write are taken every cycle and give no result.
//   A render cell request reads the font and palette stores on the transfer edge
//   and then yields eight row transfers, top row first, on the output channel.
// Output channel (out_valid_o / out_stall_i / out_data_o): one row per transfer,
//   last_row marks row 7. Rows are registered, computed from the registered store reads.
// Throughput: one row per cycle while the output is not stalled, paced by the row
//   counter in the row generator. The next cell is taken on the edge the eighth
//   row moves into the output register, so cells stream with no gap. Non-cell
//   requests pass even while a cell is emitting.
// Stall: a stalled output holds its row; the row generator waits, and once it is
//   full a further cell request sees in_stall_o high.
// Config (cfg_valid_i / cfg_ready_o / cfg_data_i): blink half period, always ready;
//   write it only while idle.
// Reset: blink count cleared, half period 50000, no rows pending. Font and palette
//   contents are undefined until written; no clearing pass.
module text_cell_glyph_renderer_top import tcgr_pkg::*; #(
  parameter int unsigned FONT_WORDS = FontWordsDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  localparam int unsigned FontAw = $clog2(FONT_WORDS);

  logic        in_xfer;
  logic        blink_on;
  cell_ctl_t   cell_ctl;
  row_stat_t   row_stat;
  logic [15:0] word0, word1;
  logic [11:0] fg_raw, bg_raw;

  // only a cell request needs the row generator free
  assign in_stall_o  = (in_data_i.req_type == REQ_CELL) && row_stat.busy
                       && !row_stat.release_now;
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  assign cell_ctl.load  = in_xfer && (in_data_i.req_type == REQ_CELL);
  assign cell_ctl.blink = blink_on && in_data_i.cell_word[7];

  tcgr_blink u_blink (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tick_i     (in_xfer && (in_data_i.req_type == REQ_TICK)),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .blink_on_o (blink_on)
  );

  // character c lives at words 2c (even bank) and 2c+1 (odd bank)
  tcgr_font_mem #(
    .FONT_WORDS (FONT_WORDS)
  ) u_font (
    .clk_i    (clk_i),
    .we_i     (in_xfer && (in_data_i.req_type == REQ_FONT)),
    .waddr_i  (in_data_i.store_addr[FontAw-1:0]),
    .wdata_i  (in_data_i.store_data),
    .re_i     (cell_ctl.load),
    .rindex_i (in_data_i.cell_word[FontAw-2:0]),
    .word0_o  (word0),
    .word1_o  (word1)
  );

  tcgr_palette_mem u_pal (
    .clk_i    (clk_i),
    .we_i     (in_xfer && (in_data_i.req_type == REQ_PAL)),
    .waddr_i  (in_data_i.store_addr[3:0]),
    .wdata_i  (in_data_i.store_data[11:0]),
    .re_i     (cell_ctl.load),
    .fg_idx_i (in_data_i.cell_word[15:12]),
    .bg_idx_i (in_data_i.cell_word[11:8]),
    .fg_o     (fg_raw),
    .bg_o     (bg_raw)
  );

  tcgr_row_gen u_rows (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (cell_ctl),
    .word0_i     (word0),
    .word1_i     (word1),
    .fg_i        (fg_raw),
    .bg_i        (bg_raw),
    .stat_o      (row_stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

### verif/tb_text_cell_glyph_renderer_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the text cell glyph renderer: directed, blink and random traffic.
module tb_text_cell_glyph_renderer_top;
  import tcgr_pkg::*;

  // A few hundred requests with every cell under heavy output stall finish well
  // inside the limit, which leaves a wide margin.
  localparam int unsigned CycleLimit  = 1_000_000;
  // Quiet tail after the last owed row has come out, for margin.
  localparam int unsigned DrainCycles = 8;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_data_o;
  logic      cfg_valid_i = 1'b0;
  logic      cfg_ready_o;
  logic [15:0] cfg_data_i = 16'd0;

  always #6 clk_i = ~clk_i;

  text_cell_glyph_renderer_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  // ---------------------------------------------------------------------------
  // Shadow copy of the block state, updated on every accepted transfer.
  // The written flags keep the stimulus away from entries never loaded.
  // ---------------------------------------------------------------------------
  logic [15:0] glyph_mem       [256];
  logic [11:0] palette_mem     [16];
  bit          glyph_written   [256];
  bit          palette_written [16];
  logic [16:0] blink_ticks = '0;
  logic [15:0] half_period = BlinkHalfReset;

  out_item_t   pending_rows [$];  // rows still owed by the block, oldest first
  bit          failed = 1'b0;

  // Pacing: percent chance per cycle that the sender holds off / the sink stalls.
  int unsigned gap_pct   = 0;
  int unsigned stall_pct = 0;

  // 4-bit channel to 8 bits: n * 0x11
  function automatic logic [23:0] nibble_expand(input logic [11:0] c);
    logic [7:0] r, g, b;
    r = 8'(c[11:8]) * 8'h11;
    g = 8'(c[7:4]) * 8'h11;
    b = 8'(c[3:0]) * 8'h11;
    return {r, g, b};
  endfunction

  // Apply one request to the shadow state; a cell queues its eight rows.
  function automatic void predict_glyph_rows(input in_item_t it);
    logic [16:0] wrap_at;
    logic [6:0]  ch;
    logic [15:0] w0, w1;
    logic [11:0] fg_raw, bg_raw;
    logic [23:0] fg, bg;
    out_item_t   row;
    int          r;
    case (it.req_type)
      REQ_TICK: begin
        wrap_at     = {half_period, 1'b0};
        blink_ticks = blink_ticks + 17'd1;  // wraps at 2^17 by width
        if (blink_ticks > wrap_at) blink_ticks = blink_ticks - wrap_at;
      end
      REQ_FONT: begin
        glyph_mem[it.store_addr]     = it.store_data;
        glyph_written[it.store_addr] = 1'b1;
      end
      REQ_PAL: begin
        palette_mem[it.store_addr[3:0]]     = it.store_data[11:0];
        palette_written[it.store_addr[3:0]] = 1'b1;
      end
      default: begin
        ch     = it.cell_word[6:0];
        w0     = glyph_mem[{ch, 1'b0}];
        w1     = glyph_mem[{ch, 1'b1}];
        bg_raw = palette_mem[it.cell_word[11:8]];
        fg_raw = palette_mem[it.cell_word[15:12]];
        // blink phase on: glyph disappears into the background
        if (it.cell_word[7] && blink_ticks > {1'b0, half_period}) fg_raw = bg_raw;
        fg = nibble_expand(fg_raw);
        bg = nibble_expand(bg_raw);
        for (r = 0; r < 8; r++) begin
          row.pixel_row  = 3'(r);
          row.pixel_col0 = w0[8 + r] ? fg : bg;
          row.pixel_col1 = w0[r]     ? fg : bg;
          row.pixel_col2 = w1[8 + r] ? fg : bg;
          row.pixel_col3 = w1[r]     ? fg : bg;
          row.last_row   = (r == 7);
          pending_rows.push_back(row);
        end
      end
    endcase
  endfunction

  function automatic in_item_t make_request(input req_type_e kind, input logic [7:0] addr,
                                            input logic [15:0] data,
                                            input logic [15:0] cell_w);
    in_item_t it;
    it.req_type   = kind;
    it.store_addr = addr;
    it.store_data = data;
    it.cell_word  = cell_w;
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side. Valid is left high after a transfer so back-to-back requests
  // never see a low/high pair of updates in one step.
  // ---------------------------------------------------------------------------
  task automatic send_request(input in_item_t it);
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_glyph_rows(it);
  endtask

  // Drop valid and let every owed row come out, then a short tail.
  task automatic wait_quiet();
    in_valid_i <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Blink half period is only written with the block idle.
  task automatic write_half_period(input logic [15:0] hp);
    wait_quiet();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= hp;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    half_period = hp;
    cfg_valid_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random stall, and a field-by-field check of each row transfer.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) out_stall_i <= ($urandom_range(99) < stall_pct);

  function automatic void check_field(input string name, input logic [23:0] want,
                                      input logic [23:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      failed = 1'b1;
    end
  endfunction

  always @(posedge clk_i) begin : check_rows
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_rows.size() == 0) begin
        $error("row transfer with nothing owed: %0h", out_data_o);
        failed = 1'b1;
      end else begin
        want = pending_rows.pop_front();
        check_field("pixel_row",  24'(want.pixel_row), 24'(out_data_o.pixel_row));
        check_field("pixel_col0", want.pixel_col0,     out_data_o.pixel_col0);
        check_field("pixel_col1", want.pixel_col1,     out_data_o.pixel_col1);
        check_field("pixel_col2", want.pixel_col2,     out_data_o.pixel_col2);
        check_field("pixel_col3", want.pixel_col3,     out_data_o.pixel_col3);
        check_field("last_row",   24'(want.last_row),  24'(out_data_o.last_row));
      end
    end
  end

  int unsigned cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Store extremes: first/last glyph words, palette 0 and 15, ignored high bits,
  // all-ones/all-zeros glyphs, fg == bg, overwrite of a loaded word.
  task automatic test_store_extremes();
    send_request(make_request(REQ_FONT, 8'h00, 16'hA55A, 16'hFFFF));
    send_request(make_request(REQ_FONT, 8'h01, 16'h0FF0, 16'h0000));
    send_request(make_request(REQ_FONT, 8'hFE, 16'hFFFF, 16'h1234));
    send_request(make_request(REQ_FONT, 8'hFF, 16'h0000, 16'hEDCB));
    // upper address nibble and top data nibble must be dropped
    send_request(make_request(REQ_PAL, 8'hF0, 16'hF000, 16'h0000));
    send_request(make_request(REQ_PAL, 8'h0F, 16'hFFFF, 16'hFFFF));
    send_request(make_request(REQ_PAL, 8'hA5, 16'h5A5C, 16'h8000));
    send_request(make_request(REQ_CELL, 8'hFF, 16'hFFFF, 16'hF000));
    // blink bit with the blink phase still off
    send_request(make_request(REQ_CELL, 8'h00, 16'h0000, 16'hF080));
    send_request(make_request(REQ_CELL, 8'h5A, 16'hA5A5, 16'h0F7F));
    send_request(make_request(REQ_CELL, 8'hC3, 16'h3C3C, 16'h55FF));
    send_request(make_request(REQ_FONT, 8'hFF, 16'h8001, 16'h7FFF));
    send_request(make_request(REQ_CELL, 8'h00, 16'h0000, 16'hF57F));
  endtask

  // Blink phase edges with the shortest half periods: count == half is off,
  // count above half is on, and the wrap past twice the half period.
  task automatic test_blink_phase();
    write_half_period(16'd1);
    send_request(make_request(REQ_CELL, 8'h11, 16'h2222, 16'hF080));
    send_request(make_request(REQ_TICK, 8'hFF, 16'hFFFF, 16'hFFFF));
    send_request(make_request(REQ_CELL, 8'h00, 16'h0000, 16'hF080));
    send_request(make_request(REQ_TICK, 8'h00, 16'h0000, 16'h0000));
    send_request(make_request(REQ_CELL, 8'h00, 16'h0000, 16'hF080));
    send_request(make_request(REQ_CELL, 8'h00, 16'h0000, 16'hF000));
    send_request(make_request(REQ_TICK, 8'h00, 16'h0000, 16'h0000));
    send_request(make_request(REQ_CELL, 8'h00, 16'h0000, 16'hF080));
    write_half_period(16'd2);
    send_request(make_request(REQ_TICK, 8'h00, 16'h0000, 16'h0000));
    send_request(make_request(REQ_CELL, 8'h00, 16'h0000, 16'h5F80));
    send_request(make_request(REQ_TICK, 8'h00, 16'h0000, 16'h0000));
    send_request(make_request(REQ_CELL, 8'h00, 16'h0000, 16'h5F80));
  endtask

  // Mixed traffic with random content. Every store entry a cell reads gets
  // loaded first if it never was.
  task automatic test_random_traffic(input int unsigned count);
    in_item_t    it;
    int unsigned pick;
    logic [6:0]  ch;
    repeat (count) begin
      pick = $urandom_range(99);
      it   = make_request(REQ_TICK, 8'($urandom), 16'($urandom), 16'($urandom));
      if (pick < 25) begin
        it.req_type = REQ_TICK;
      end else if (pick < 40) begin
        it.req_type = REQ_FONT;
      end else if (pick < 50) begin
        it.req_type = REQ_PAL;
      end else begin
        it.req_type = REQ_CELL;
        ch = it.cell_word[6:0];
        if (!glyph_written[{ch, 1'b0}])
          send_request(make_request(REQ_FONT, {ch, 1'b0}, 16'($urandom), 16'($urandom)));
        if (!glyph_written[{ch, 1'b1}])
          send_request(make_request(REQ_FONT, {ch, 1'b1}, 16'($urandom), 16'($urandom)));
        if (!palette_written[it.cell_word[15:12]])
          send_request(make_request(REQ_PAL, {4'($urandom), it.cell_word[15:12]},
                                    16'($urandom), 16'($urandom)));
        if (!palette_written[it.cell_word[11:8]])
          send_request(make_request(REQ_PAL, {4'($urandom), it.cell_word[11:8]},
                                    16'($urandom), 16'($urandom)));
      end
      send_request(it);
    end
  endtask

  // Largest half period: blinking cells around a few ticks, starting from
  // whatever count the random traffic left behind.
  task automatic test_counter_extremes();
    write_half_period(16'hFFFF);
    send_request(make_request(REQ_CELL, 8'h00, 16'h0000, 16'hF080));
    repeat (4)
      send_request(make_request(REQ_TICK, 8'($urandom), 16'($urandom), 16'($urandom)));
    send_request(make_request(REQ_CELL, 8'h00, 16'h0000, 16'hF080));
    send_request(make_request(REQ_TICK, 8'h00, 16'h0000, 16'h0000));
    send_request(make_request(REQ_CELL, 8'h00, 16'h0000, 16'hF080));
  endtask

  initial begin
    gap_pct   = 30;
    stall_pct = 70;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_store_extremes();
    test_blink_phase();

    write_half_period(16'($urandom_range(1, 6)));
    test_random_traffic(70);

    gap_pct   = 70;
    stall_pct = 30;
    write_half_period(16'($urandom_range(1, 6)));
    test_random_traffic(70);

    // no hold-off on either side: cells stream back to back
    gap_pct   = 0;
    stall_pct = 0;
    write_half_period(16'($urandom_range(1, 65535)));
    test_random_traffic(70);
    test_counter_extremes();

    wait_quiet();
    if (!failed) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
